// ===== hdl/box_blur_3x3_edge_aware_unit_macros.svh =====
// Assertion helpers, clocked on i_clk and idle during reset.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_UNIT_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_UNIT_MACROS_SVH

// Same-cycle implication.
`define BBE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BBE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bbe_pkg.sv =====
`default_nettype none
package bbe_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int PIX_W          = 8;
    localparam int SUM_W          = 12;
    localparam int CNT_W          = 4;
    localparam int REM_W          = CNT_W + 1;
    localparam int CFG_W_W        = 11;
    localparam int CFG_H_W        = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int DIV_STEPS      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // channel 2 red, 1 green, 0 blue
    typedef logic [2:0][PIX_W-1:0] t_rgb;
    typedef logic [2:0][SUM_W-1:0] t_sum3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PIX_RD,
        S_PIX_WR,
        S_PIX_NEW,
        S_DR_FIRST,
        S_DR_RD,
        S_DR_ACC,
        S_DIV_GO,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic take;
        logic pix_rd;
        logic pix_wr;
        logic pix_adv;
        logic acc_old;
        logic acc_new;
        logic dr_rd;
        logic dr_acc;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic draining;
        logic row_start;
        logic new_out;
        logic drain_first;
        logic k_last;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== hdl/bbe_div.sv =====
`default_nettype none
module bbe_div import bbe_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_sum3            i_sum,
    input  wire logic [CNT_W-1:0] i_cnt,
    output logic                  o_done,
    output t_rgb                  o_q
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic                    r_busy;
    logic                    r_done;
    logic [STEP_W-1:0]       r_step;
    logic [REM_W-1:0]        r_den;
    logic [2:0][REM_W-1:0]   r_rem;
    t_rgb                    r_low;
    t_rgb                    r_q;

    logic [2:0][REM_W-1:0]   n_rem;
    logic [2:0]              qbit;
    logic [2:0][SUM_W:0]     num;

    // numerator 2*sum+cnt, divisor 2*cnt; quotient fits 8 bits so the
    // top bits already sit below the divisor
    always_comb begin
        logic [REM_W:0] trial;
        for (int ch = 0; ch < 3; ch++) begin
            num[ch] = {i_sum[ch], 1'b0} + (SUM_W+1)'(i_cnt);
            trial = {r_rem[ch], r_low[ch][PIX_W-1]};
            if (trial >= {1'b0, r_den}) begin
                n_rem[ch] = REM_W'(trial - {1'b0, r_den});
                qbit[ch] = 1'b1;
            end else begin
                n_rem[ch] = trial[REM_W-1:0];
                qbit[ch] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= {i_cnt, 1'b0};
            for (int ch = 0; ch < 3; ch++) begin
                r_rem[ch] <= num[ch][SUM_W:PIX_W];
                r_low[ch] <= num[ch][PIX_W-1:0];
            end
        end else if (r_busy) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_rem[ch] <= n_rem[ch];
                r_low[ch] <= {r_low[ch][PIX_W-2:0], 1'b0};
                r_q[ch]   <= {r_q[ch][PIX_W-2:0], qbit[ch]};
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule
`default_nettype wire

// ===== hdl/bbe_dpath.sv =====
`default_nettype none
module bbe_dpath import bbe_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic                  i_op,
    input  wire logic [PIX_W-1:0]      i_red_in,
    input  wire logic [PIX_W-1:0]      i_green_in,
    input  wire logic [PIX_W-1:0]      i_blue_in,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_ready,
    output logic                       o_valid,
    output logic [PIX_W-1:0]           o_red_out,
    output logic [PIX_W-1:0]           o_green_out,
    output logic [PIX_W-1:0]           o_blue_out,
    output logic                       o_frame_end
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CFG_W_W-1:0] r_cfg_w;
    logic [CFG_H_W-1:0] r_cfg_h;
    logic [WW-1:0]      eff_w;
    logic [HW-1:0]      eff_h;

    logic [RW-1:0]      r_in_row;
    logic [CW-1:0]      r_in_col;
    logic [WW-1:0]      r_drain_col;
    logic               r_draining;
    logic               r_op;
    t_rgb               r_px;
    logic [1:0]         r_k;
    logic               r_k_ok;
    logic               r_last;

    t_rgb               mem_up [MAX_WIDTH];
    t_rgb               mem_lo [MAX_WIDTH];
    t_rgb               r_rd_up;
    t_rgb               r_rd_lo;
    t_rgb               r_win [3][3];

    t_sum3              r_acc;
    logic [CNT_W-1:0]   r_cnt;
    t_sum3              win_sum;
    logic [CNT_W-1:0]   win_cnt;

    logic               r_out_valid;
    t_rgb               r_out_rgb;
    logic               r_out_end;

    logic               h_ge2;
    logic               col_last;
    logic               row_last;
    logic               drain_last;
    logic               rr_ge3;
    logic [WW+1:0]      dr_a;
    logic               dr_ok;
    logic [CW-1:0]      rd_addr;
    logic               div_done;
    t_rgb               div_q;

    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_cfg_h);
        end
    end

    assign h_ge2      = (eff_h >= HW'(2));
    assign col_last   = (32'(r_in_col) + 32'd1 >= 32'(eff_w));
    assign row_last   = (32'(r_in_row) + 32'd1 >= 32'(eff_h));
    assign drain_last = (32'(r_drain_col) + 32'd1 >= 32'(eff_w) + 32'(h_ge2));
    assign rr_ge3     = r_draining ? (eff_h >= HW'(3)) : (r_in_row >= RW'(3));

    // drain neighbor column: center is drain_col minus one when two rows exist
    assign dr_a  = (WW+2)'(int'(r_drain_col) - int'(h_ge2) - 1 + int'(r_k));
    assign dr_ok = !dr_a[WW+1] && (dr_a < {2'b00, eff_w});
    assign rd_addr = i_cmd.dr_rd ? dr_a[CW-1:0] : r_in_col;

    // masked window sum; old form is the row-end pixel before the shift
    always_comb begin
        logic en;
        win_sum = '0;
        win_cnt = '0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                if (i_cmd.acc_new) begin
                    en = (k != 0 || r_in_col >= CW'(2)) && (j != 0 || r_in_row >= RW'(2));
                end else begin
                    en = (k != 0) && (k != 1 || eff_w >= WW'(2)) && (j != 0 || rr_ge3);
                end
                for (int ch = 0; ch < 3; ch++) begin
                    win_sum[ch] = win_sum[ch] + (en ? SUM_W'(r_win[k][j][ch]) : '0);
                end
                win_cnt = win_cnt + CNT_W'(en);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_wr) begin
            mem_up[r_in_col] <= r_rd_lo;
            mem_lo[r_in_col] <= r_px;
        end
        if (i_cmd.pix_rd || i_cmd.dr_rd) begin
            r_rd_up <= mem_up[rd_addr];
            r_rd_lo <= mem_lo[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_px <= {i_red_in, i_green_in, i_blue_in};
        end
        if (i_cmd.pix_wr) begin
            for (int j = 0; j < 3; j++) begin
                r_win[0][j] <= r_win[1][j];
                r_win[1][j] <= r_win[2][j];
            end
            r_win[2][0] <= r_rd_up;
            r_win[2][1] <= r_rd_lo;
            r_win[2][2] <= r_px;
        end
        if (i_cmd.take) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cmd.acc_old || i_cmd.acc_new) begin
            r_acc <= win_sum;
            r_cnt <= win_cnt;
        end else if (i_cmd.dr_acc && r_k_ok) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_acc[ch] <= r_acc[ch] + (h_ge2 ? SUM_W'(r_rd_up[ch]) : '0)
                           + SUM_W'(r_rd_lo[ch]);
            end
            r_cnt <= r_cnt + (h_ge2 ? CNT_W'(2) : CNT_W'(1));
        end
        if (i_cmd.dr_rd) begin
            r_k_ok <= dr_ok;
        end
        if (i_cmd.out_load) begin
            r_out_rgb <= div_q;
            r_out_end <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= CFG_W_W'(1);
            r_cfg_h     <= CFG_H_W'(1);
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_drain_col <= '0;
            r_draining  <= 1'b0;
            r_op        <= OP_PIXEL;
            r_k         <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_op   <= i_op;
                r_k    <= '0;
                r_last <= 1'b0;
            end
            if (i_cmd.dr_acc) begin
                r_k <= r_k + 2'd1;
            end
            if (i_cmd.pix_adv) begin
                if (col_last) begin
                    r_in_col <= '0;
                    if (row_last) begin
                        r_in_row    <= '0;
                        r_draining  <= 1'b1;
                        r_drain_col <= '0;
                    end else begin
                        r_in_row <= r_in_row + RW'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end
            if (i_cmd.div_start && r_op == OP_DRAIN) begin
                r_last <= drain_last;
                if (drain_last) begin
                    r_draining  <= 1'b0;
                    r_drain_col <= '0;
                    r_in_row    <= '0;
                    r_in_col    <= '0;
                end else begin
                    r_drain_col <= r_drain_col + WW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            // restart the frame on a write to the width or height register
            if (i_cfg_we && (i_cfg_addr == REG_FRAME_WIDTH ||
                             i_cfg_addr == REG_FRAME_HEIGHT)) begin
                if (i_cfg_addr == REG_FRAME_WIDTH) begin
                    r_cfg_w <= i_cfg_wdata[CFG_W_W-1:0];
                end else begin
                    r_cfg_h <= i_cfg_wdata[CFG_H_W-1:0];
                end
                r_in_row    <= '0;
                r_in_col    <= '0;
                r_drain_col <= '0;
                r_draining  <= 1'b0;
            end
        end
    end

    bbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_sum   (r_acc),
        .i_cnt   (r_cnt),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    assign o_stat.draining    = r_draining;
    assign o_stat.row_start   = (r_in_col == '0) && (r_in_row >= RW'(2));
    assign o_stat.new_out     = (r_in_col >= CW'(1)) && (r_in_row >= RW'(1));
    assign o_stat.drain_first = h_ge2 && (r_drain_col == '0);
    assign o_stat.k_last      = (r_k == 2'd2);
    assign o_stat.div_done    = div_done;
    assign o_stat.out_free    = !r_out_valid || i_ready;

    assign o_valid     = r_out_valid;
    assign o_red_out   = r_out_rgb[2];
    assign o_green_out = r_out_rgb[1];
    assign o_blue_out  = r_out_rgb[0];
    assign o_frame_end = r_out_end;

endmodule
`default_nettype wire

// ===== hdl/bbe_ctrl.sv =====
`default_nettype none
module bbe_ctrl import bbe_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic  i_op,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_ready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_PIXEL) begin
                        // drop pixels while draining
                        n_state = i_stat.draining ? S_IDLE : S_PIX_RD;
                    end else if (!i_stat.draining) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = i_stat.drain_first ? S_DR_FIRST : S_DR_RD;
                    end
                end
            end
            S_PIX_RD:   n_state = S_PIX_WR;
            S_PIX_WR:   n_state = S_PIX_NEW;
            S_PIX_NEW: begin
                n_state = (i_stat.row_start || i_stat.new_out) ? S_DIV_GO : S_IDLE;
            end
            S_DR_FIRST: n_state = S_DIV_GO;
            S_DR_RD:    n_state = S_DR_ACC;
            S_DR_ACC:   n_state = i_stat.k_last ? S_DIV_GO : S_DR_RD;
            S_DIV_GO:   n_state = S_DIV;
            S_DIV:      n_state = i_stat.div_done ? S_OUT : S_DIV;
            S_OUT:      n_state = i_stat.out_free ? S_IDLE : S_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
            end
            S_PIX_RD: begin
                o_cmd.pix_rd  = 1'b1;
                o_cmd.acc_old = i_stat.row_start;
            end
            S_PIX_WR:   o_cmd.pix_wr = 1'b1;
            S_PIX_NEW: begin
                o_cmd.pix_adv = 1'b1;
                o_cmd.acc_new = i_stat.new_out;
            end
            S_DR_FIRST: o_cmd.acc_old = 1'b1;
            S_DR_RD:    o_cmd.dr_rd = 1'b1;
            S_DR_ACC:   o_cmd.dr_acc = 1'b1;
            S_DIV_GO:   o_cmd.div_start = 1'b1;
            S_OUT:      o_cmd.out_load = i_stat.out_free;
            default:    o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/box_blur_3x3_edge_aware_unit.sv =====
// Channel  Handshake          Payload
// input    i_valid / o_ready  i_op, i_red_in, i_green_in, i_blue_in
// output   o_valid / i_ready  o_red_out, o_green_out, o_blue_out, o_frame_end
// config   i_cfg_we           i_cfg_addr, i_cfg_wdata
//
// One transaction at a time: an ignored item, a pixel with or without a result
// or a drain finishes before the next item is taken. Their length is set by the
// 8-step shared divider and the single read port of the line stores (a drain
// reads three columns in turn unless first of a frame of two or more rows).
// Reset is synchronous; line stores are not cleared. A stalled output holds
// in its register while the next transaction is already taken.
`default_nettype none
`include "box_blur_3x3_edge_aware_unit_macros.svh"
module box_blur_3x3_edge_aware_unit import bbe_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_op,
    input  wire logic [PIX_W-1:0]      i_red_in,
    input  wire logic [PIX_W-1:0]      i_green_in,
    input  wire logic [PIX_W-1:0]      i_blue_in,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [PIX_W-1:0]           o_red_out,
    output logic [PIX_W-1:0]           o_green_out,
    output logic [PIX_W-1:0]           o_blue_out,
    output logic                       o_frame_end,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    bbe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_ready (o_ready)
    );

    bbe_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_op        (i_op),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_frame_end (o_frame_end)
    );

    `BBE_ASSERT_IMP(a_load_into_free, w_cmd.out_load, !o_valid || i_ready, "output overwritten")
    `BBE_ASSERT_IMP(a_div_latency, w_stat.div_done, $past(w_cmd.div_start, 9), "divider timing")
    `BBE_ASSERT_NXT(a_div_blocks_in, w_cmd.div_start, !o_ready, "input taken mid divide")

endmodule
`default_nettype wire
